@@ rtl/trs_pkg.sv @@
// trs_pkg: widths, item structs and fixed-point helpers for the trs transform composer
// depends on nothing; imported by every module of the block

package trs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W - FRAC_BITS;   // floored product width
   localparam int SUM_W     = PROD_W + 3;               // one - 2*(a+b) without loss

   typedef logic signed [DATA_W-1:0] fix_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   localparam fix_type FIX_ONE = fix_type'(64'sd1 <<< FRAC_BITS);
   localparam fix_type FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam fix_type FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam fix_type FIX_ZERO = '0;

   localparam logic [1:0] ROW_LAST = 2'd3;

   typedef struct packed {
      fix_type x;
      fix_type y;
      fix_type z;
   } vec3_type;

   typedef struct packed {
      fix_type x;
      fix_type y;
      fix_type z;
      fix_type w;
   } quat_type;

   typedef struct packed {
      vec3_type trans;
      quat_type quat;
      vec3_type scale;
   } req_item_type;

   typedef struct packed {
      prod_type xx;
      prod_type yy;
      prod_type zz;
      prod_type xy;
      prod_type xz;
      prod_type yz;
      prod_type wx;
      prod_type wy;
      prod_type wz;
   } prod_set_type;

   typedef struct packed {
      prod_set_type p;
      vec3_type     trans;
      vec3_type     scale;
   } prod_item_type;

   typedef struct packed {
      fix_type c0;
      fix_type c1;
      fix_type c2;
   } row3_type;

   typedef struct packed {
      row3_type r0;
      row3_type r1;
      row3_type r2;
   } mat3_type;

   typedef struct packed {
      mat3_type rot;
      vec3_type trans;
      vec3_type scale;
   } rot_item_type;

   typedef struct packed {
      prod_type c0;
      prod_type c1;
      prod_type c2;
   } prow_type;

   typedef struct packed {
      prow_type r0;
      prow_type r1;
      prow_type r2;
   } pmat_type;

   typedef struct packed {
      pmat_type m;
      vec3_type trans;
   } scl_item_type;

   // exact product, shifted right with rounding toward minus infinity
   function automatic prod_type fx_mul(fix_type a, fix_type b);
      logic signed [2*DATA_W-1:0] full;
      full = a * b;
      return full[2*DATA_W-1:FRAC_BITS];
   endfunction

   function automatic sum_type sum_ext(prod_type v);
      return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
   endfunction

   function automatic fix_type sat_fix(sum_type v);
      sum_type hi;
      sum_type lo;
      hi = {{(SUM_W-DATA_W){1'b0}}, FIX_MAX};
      lo = {{(SUM_W-DATA_W){1'b1}}, FIX_MIN};
      if (v > hi) begin
         return FIX_MAX;
      end else if (v < lo) begin
         return FIX_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

@@ rtl/trs_transform_compose.sv @@
// trs_transform_compose: top level of the translate-rotate-scale transform composer
// depends on trs_pkg, trs_prod, trs_rot, trs_scale and trs_rows

// Each request carries a translation, a rotation quaternion (not normalised) and a per-axis
// scale, all signed Q16.16, and produces the 4x4 matrix T*R*S as four responses, row 0
// first; the row with rsp_last_row high is the fixed bottom row 0,0,0,1. Products round
// toward minus infinity, rotation elements and scaled elements saturate to 32 bits and the
// translation passes unchanged into col3. The datapath is a four-register pipeline: the
// nine quaternion products, the rotation sums with saturation, the nine scale products, and
// a row register that holds one finished matrix and hands it out a row per cycle while the
// response side is ready. With the pipeline empty, a request passes through the product,
// rotation, scale and row registers in that order before its first row is on the response
// ports. The single response channel carries four rows per request and so limits the
// request rate; the three stages ahead of the row register keep taking requests while a
// matrix waits, so up to four requests can be in flight.

module trs_transform_compose import trs_pkg::*; (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  fix_type    req_trans_x,
   input  fix_type    req_trans_y,
   input  fix_type    req_trans_z,
   input  fix_type    req_quat_x,
   input  fix_type    req_quat_y,
   input  fix_type    req_quat_z,
   input  fix_type    req_quat_w,
   input  fix_type    req_scale_x,
   input  fix_type    req_scale_y,
   input  fix_type    req_scale_z,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_row_index,
   output fix_type    rsp_col0,
   output fix_type    rsp_col1,
   output fix_type    rsp_col2,
   output fix_type    rsp_col3,
   output logic       rsp_last_row
);

   // request fields gathered into one bundle
   req_item_type  req_item;

   // stage to stage handshakes
   logic          prod_valid;
   logic          prod_ready;
   prod_item_type prod_item;
   logic          rot_valid;
   logic          rot_ready;
   rot_item_type  rot_item;
   logic          scl_valid;
   logic          scl_ready;
   scl_item_type  scl_item;

   assign req_item.trans.x = req_trans_x;
   assign req_item.trans.y = req_trans_y;
   assign req_item.trans.z = req_trans_z;
   assign req_item.quat.x  = req_quat_x;
   assign req_item.quat.y  = req_quat_y;
   assign req_item.quat.z  = req_quat_z;
   assign req_item.quat.w  = req_quat_w;
   assign req_item.scale.x = req_scale_x;
   assign req_item.scale.y = req_scale_y;
   assign req_item.scale.z = req_scale_z;

   // stage 1: xx, yy, zz, xy, xz, yz, wx, wy, wz
   trs_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_item),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_item)
   );

   // stage 2: rotation matrix, each element saturated
   trs_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_item),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_data  (rot_item)
   );

   // stage 3: column j times scale j
   trs_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_ready  (rot_ready),
      .in_data   (rot_item),
      .out_valid (scl_valid),
      .out_ready (scl_ready),
      .out_data  (scl_item)
   );

   // stage 4: saturation and row-by-row response
   trs_rows u_rows (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (scl_valid),
      .in_ready      (scl_ready),
      .in_data       (scl_item),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_row_index (rsp_row_index),
      .out_col0      (rsp_col0),
      .out_col1      (rsp_col1),
      .out_col2      (rsp_col2),
      .out_col3      (rsp_col3),
      .out_last_row  (rsp_last_row)
   );

endmodule

@@ rtl/trs_prod.sv @@
// trs_prod: first pipeline stage, the nine quaternion component products
// depends on trs_pkg

module trs_prod import trs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  req_item_type  in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output prod_item_type out_data
);

   logic          valid_ff;
   logic          valid_in;
   prod_item_type data_ff;
   prod_item_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in.p.xx  = fx_mul(in_data.quat.x, in_data.quat.x);
      data_in.p.yy  = fx_mul(in_data.quat.y, in_data.quat.y);
      data_in.p.zz  = fx_mul(in_data.quat.z, in_data.quat.z);
      data_in.p.xy  = fx_mul(in_data.quat.x, in_data.quat.y);
      data_in.p.xz  = fx_mul(in_data.quat.x, in_data.quat.z);
      data_in.p.yz  = fx_mul(in_data.quat.y, in_data.quat.z);
      data_in.p.wx  = fx_mul(in_data.quat.w, in_data.quat.x);
      data_in.p.wy  = fx_mul(in_data.quat.w, in_data.quat.y);
      data_in.p.wz  = fx_mul(in_data.quat.w, in_data.quat.z);
      data_in.trans = in_data.trans;
      data_in.scale = in_data.scale;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/trs_rot.sv @@
// trs_rot: second pipeline stage, rotation matrix sums with saturation
// depends on trs_pkg

module trs_rot import trs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  prod_item_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output rot_item_type  out_data
);

   logic         valid_ff;
   logic         valid_in;
   rot_item_type data_ff;
   rot_item_type data_in;

   sum_type xx, yy, zz, xy, xz, yz, wx, wy, wz;
   sum_type one;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      xx  = sum_ext(in_data.p.xx);
      yy  = sum_ext(in_data.p.yy);
      zz  = sum_ext(in_data.p.zz);
      xy  = sum_ext(in_data.p.xy);
      xz  = sum_ext(in_data.p.xz);
      yz  = sum_ext(in_data.p.yz);
      wx  = sum_ext(in_data.p.wx);
      wy  = sum_ext(in_data.p.wy);
      wz  = sum_ext(in_data.p.wz);
      one = {{(SUM_W-DATA_W){1'b0}}, FIX_ONE};

      data_in.rot.r0.c0 = sat_fix(one - ((yy + zz) <<< 1));
      data_in.rot.r0.c1 = sat_fix((xy - wz) <<< 1);
      data_in.rot.r0.c2 = sat_fix((xz + wy) <<< 1);
      data_in.rot.r1.c0 = sat_fix((xy + wz) <<< 1);
      data_in.rot.r1.c1 = sat_fix(one - ((xx + zz) <<< 1));
      data_in.rot.r1.c2 = sat_fix((yz - wx) <<< 1);
      data_in.rot.r2.c0 = sat_fix((xz - wy) <<< 1);
      data_in.rot.r2.c1 = sat_fix((yz + wx) <<< 1);
      data_in.rot.r2.c2 = sat_fix(one - ((xx + yy) <<< 1));
      data_in.trans     = in_data.trans;
      data_in.scale     = in_data.scale;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/trs_scale.sv @@
// trs_scale: third pipeline stage, each rotation column times its scale
// depends on trs_pkg

module trs_scale import trs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rot_item_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output scl_item_type out_data
);

   logic         valid_ff;
   logic         valid_in;
   scl_item_type data_ff;
   scl_item_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in.m.r0.c0 = fx_mul(in_data.rot.r0.c0, in_data.scale.x);
      data_in.m.r0.c1 = fx_mul(in_data.rot.r0.c1, in_data.scale.y);
      data_in.m.r0.c2 = fx_mul(in_data.rot.r0.c2, in_data.scale.z);
      data_in.m.r1.c0 = fx_mul(in_data.rot.r1.c0, in_data.scale.x);
      data_in.m.r1.c1 = fx_mul(in_data.rot.r1.c1, in_data.scale.y);
      data_in.m.r1.c2 = fx_mul(in_data.rot.r1.c2, in_data.scale.z);
      data_in.m.r2.c0 = fx_mul(in_data.rot.r2.c0, in_data.scale.x);
      data_in.m.r2.c1 = fx_mul(in_data.rot.r2.c1, in_data.scale.y);
      data_in.m.r2.c2 = fx_mul(in_data.rot.r2.c2, in_data.scale.z);
      data_in.trans   = in_data.trans;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/trs_rows.sv @@
// trs_rows: last stage, saturates the scaled matrix and sends it out row by row
// depends on trs_pkg

module trs_rows import trs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  scl_item_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [1:0]   out_row_index,
   output fix_type      out_col0,
   output fix_type      out_col1,
   output fix_type      out_col2,
   output fix_type      out_col3,
   output logic         out_last_row
);

   logic       hold_ff;
   logic       hold_in;
   logic [1:0] row_ff;
   logic [1:0] row_in;
   mat3_type   mat_ff;
   mat3_type   mat_in;
   vec3_type   trans_ff;
   logic       load;
   logic       last;

   function automatic fix_type sat_prod(prod_type v);
      return sat_fix(sum_ext(v));
   endfunction

   assign last     = (row_ff == ROW_LAST);
   assign in_ready = !hold_ff || (out_ready && last);
   assign load     = in_valid && in_ready;

   always_comb begin
      mat_in.r0.c0 = sat_prod(in_data.m.r0.c0);
      mat_in.r0.c1 = sat_prod(in_data.m.r0.c1);
      mat_in.r0.c2 = sat_prod(in_data.m.r0.c2);
      mat_in.r1.c0 = sat_prod(in_data.m.r1.c0);
      mat_in.r1.c1 = sat_prod(in_data.m.r1.c1);
      mat_in.r1.c2 = sat_prod(in_data.m.r1.c2);
      mat_in.r2.c0 = sat_prod(in_data.m.r2.c0);
      mat_in.r2.c1 = sat_prod(in_data.m.r2.c1);
      mat_in.r2.c2 = sat_prod(in_data.m.r2.c2);
   end

   always_comb begin
      hold_in = hold_ff;
      row_in  = row_ff;
      if (load) begin
         hold_in = 1'b1;
         row_in  = '0;
      end else if (hold_ff && out_ready) begin
         row_in = row_ff + 2'd1;
         if (last) begin
            hold_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         row_ff  <= '0;
      end else begin
         hold_ff <= hold_in;
         row_ff  <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mat_ff   <= mat_in;
         trans_ff <= in_data.trans;
      end
   end

   always_comb begin
      unique case (row_ff)
         2'd0: begin
            out_col0 = mat_ff.r0.c0;
            out_col1 = mat_ff.r0.c1;
            out_col2 = mat_ff.r0.c2;
            out_col3 = trans_ff.x;
         end
         2'd1: begin
            out_col0 = mat_ff.r1.c0;
            out_col1 = mat_ff.r1.c1;
            out_col2 = mat_ff.r1.c2;
            out_col3 = trans_ff.y;
         end
         2'd2: begin
            out_col0 = mat_ff.r2.c0;
            out_col1 = mat_ff.r2.c1;
            out_col2 = mat_ff.r2.c2;
            out_col3 = trans_ff.z;
         end
         default: begin
            out_col0 = FIX_ZERO;
            out_col1 = FIX_ZERO;
            out_col2 = FIX_ZERO;
            out_col3 = FIX_ONE;
         end
      endcase
   end

   assign out_valid     = hold_ff;
   assign out_row_index = row_ff;
   assign out_last_row  = last;

endmodule

@@ tb/trs_row_ledger_pkg.sv @@
// trs_row_ledger_pkg: expected-row predictor and ledger for the transform composer bench
// depends on trs_pkg for the fixed-point types and the request struct

package trs_row_ledger_pkg;
   import trs_pkg::*;

   typedef struct packed {
      logic [1:0] row_index;
      fix_type    col0;
      fix_type    col1;
      fix_type    col2;
      fix_type    col3;
      logic       last_row;
   } mat_row_type;

   localparam int unsigned REPORT_LIMIT = 10;

   class trs_row_ledger;
      mat_row_type rows_due[$];
      int unsigned faults = 0;

      // exact product, floored to the fixed-point grid
      function longint floor_mul(longint a, longint b);
         longint full;
         full = a * b;
         return full >>> FRAC_BITS;
      endfunction

      function longint clamp_word(longint v);
         if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
         end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
         end
         return v;
      endfunction

      // four rows of T*R*S for one request
      function void note_request(req_item_type r);
         longint qx, qy, qz, qw, unit;
         longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
         longint rot [3][3];
         longint sc [3];
         fix_type tr [3];
         mat_row_type row;
         qx = $signed(r.quat.x);
         qy = $signed(r.quat.y);
         qz = $signed(r.quat.z);
         qw = $signed(r.quat.w);
         sc[0] = $signed(r.scale.x);
         sc[1] = $signed(r.scale.y);
         sc[2] = $signed(r.scale.z);
         tr[0] = r.trans.x;
         tr[1] = r.trans.y;
         tr[2] = r.trans.z;
         unit = 64'sd1 <<< FRAC_BITS;

         xx = floor_mul(qx, qx);
         yy = floor_mul(qy, qy);
         zz = floor_mul(qz, qz);
         xy = floor_mul(qx, qy);
         xz = floor_mul(qx, qz);
         yz = floor_mul(qy, qz);
         wx = floor_mul(qw, qx);
         wy = floor_mul(qw, qy);
         wz = floor_mul(qw, qz);

         rot[0][0] = clamp_word(unit - 2 * (yy + zz));
         rot[0][1] = clamp_word(2 * (xy - wz));
         rot[0][2] = clamp_word(2 * (xz + wy));
         rot[1][0] = clamp_word(2 * (xy + wz));
         rot[1][1] = clamp_word(unit - 2 * (xx + zz));
         rot[1][2] = clamp_word(2 * (yz - wx));
         rot[2][0] = clamp_word(2 * (xz - wy));
         rot[2][1] = clamp_word(2 * (yz + wx));
         rot[2][2] = clamp_word(unit - 2 * (xx + yy));

         for (int i = 0; i < 3; i++) begin
            row.row_index = 2'(i);
            row.col0      = fix_type'(clamp_word(floor_mul(rot[i][0], sc[0])));
            row.col1      = fix_type'(clamp_word(floor_mul(rot[i][1], sc[1])));
            row.col2      = fix_type'(clamp_word(floor_mul(rot[i][2], sc[2])));
            row.col3      = tr[i];
            row.last_row  = 1'b0;
            rows_due.push_back(row);
         end

         row.row_index = ROW_LAST;
         row.col0      = '0;
         row.col1      = '0;
         row.col2      = '0;
         row.col3      = fix_type'(unit);
         row.last_row  = 1'b1;
         rows_due.push_back(row);
      endfunction

      function void check_row(mat_row_type got);
         mat_row_type want;
         if (rows_due.size() == 0) begin
            faults++;
            if (faults <= REPORT_LIMIT) begin
               $display("row with nothing due: idx %0d cols %h %h %h %h last %b",
                        got.row_index, got.col0, got.col1, got.col2, got.col3,
                        got.last_row);
            end
            return;
         end
         want = rows_due.pop_front();
         if (got.row_index !== want.row_index || got.col0 !== want.col0 ||
             got.col1 !== want.col1 || got.col2 !== want.col2 ||
             got.col3 !== want.col3 || got.last_row !== want.last_row) begin
            faults++;
            if (faults <= REPORT_LIMIT) begin
               $display("row mismatch: expected idx %0d cols %h %h %h %h last %b",
                        want.row_index, want.col0, want.col1, want.col2, want.col3,
                        want.last_row);
               $display("               actual idx %0d cols %h %h %h %h last %b",
                        got.row_index, got.col0, got.col1, got.col2, got.col3,
                        got.last_row);
            end
         end
      endfunction

      function int unsigned pending();
         return rows_due.size();
      endfunction
   endclass

endpackage

@@ tb/trs_transform_compose_tb.sv @@
// trs_transform_compose_tb: drives translate-rotate-scale requests into the composer and
// checks every returned matrix row against a predicted copy
// depends on trs_pkg, trs_row_ledger_pkg and the trs_transform_compose rtl

module trs_transform_compose_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import trs_pkg::*;
   import trs_row_ledger_pkg::*;

   localparam int unsigned RANDOM_REQS = 310;

   logic         clock = 1'b0;
   logic         reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item  = '0;

   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic [1:0]   rsp_row_index;
   fix_type      rsp_col0;
   fix_type      rsp_col1;
   fix_type      rsp_col2;
   fix_type      rsp_col3;
   logic         rsp_last_row;

   // set while both sides run flat out, no gaps and no stalls
   bit           steady = 1'b0;

   trs_row_ledger book;

   trs_transform_compose dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_trans_x   (req_item.trans.x),
      .req_trans_y   (req_item.trans.y),
      .req_trans_z   (req_item.trans.z),
      .req_quat_x    (req_item.quat.x),
      .req_quat_y    (req_item.quat.y),
      .req_quat_z    (req_item.quat.z),
      .req_quat_w    (req_item.quat.w),
      .req_scale_x   (req_item.scale.x),
      .req_scale_y   (req_item.scale.y),
      .req_scale_z   (req_item.scale.z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_row_index (rsp_row_index),
      .rsp_col0      (rsp_col0),
      .rsp_col1      (rsp_col1),
      .rsp_col2      (rsp_col2),
      .rsp_col3      (rsp_col3),
      .rsp_last_row  (rsp_last_row)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // idle length: half of the draws give none, most of the rest are short, a few are long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic req_item_type make_req(fix_type tx, fix_type ty, fix_type tz,
                                             fix_type qx, fix_type qy, fix_type qz,
                                             fix_type qw, fix_type sx, fix_type sy,
                                             fix_type sz);
      req_item_type r;
      r.trans.x = tx;
      r.trans.y = ty;
      r.trans.z = tz;
      r.quat.x  = qx;
      r.quat.y  = qy;
      r.quat.z  = qz;
      r.quat.w  = qw;
      r.scale.x = sx;
      r.scale.y = sy;
      r.scale.z = sz;
      return r;
   endfunction

   // style 0: any 32-bit word, style 1: within +-4.0, otherwise a corner value
   function automatic fix_type rand_word(int unsigned style);
      if (style == 0) begin
         return fix_type'($urandom);
      end else if (style == 1) begin
         return fix_type'(int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      end
      case ($urandom_range(0, 7))
         0:       return FIX_ZERO;
         1:       return FIX_ONE;
         2:       return -FIX_ONE;
         3:       return FIX_MAX;
         4:       return FIX_MIN;
         5:       return 32'sd1;
         6:       return -32'sd1;
         default: return 32'sh0080_0000;   // twice its square is 2^31, one past the upper bound
      endcase
   endfunction

   // mostly realistic transforms, then raw words, then a field-by-field mix
   function automatic req_item_type rand_req();
      int unsigned flavour;
      fix_type     w [10];
      flavour = $urandom_range(0, 9);
      for (int k = 0; k < 10; k++) begin
         if (flavour < 5) begin
            w[k] = rand_word(1);
         end else if (flavour < 8) begin
            w[k] = rand_word(0);
         end else begin
            w[k] = rand_word($urandom_range(0, 2));
         end
      end
      return make_req(w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8], w[9]);
   endfunction

   // present one request and hold it until the block takes it; called at a rising edge
   task automatic push_request(req_item_type r);
      req_valid <= 1'b1;
      req_item  <= r;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      book.note_request(r);
   endtask

   // request side
   initial begin : stimulus
      req_item_type directed [$];
      int unsigned  gap;
      bit           calm;

      book = new;

      // all zero, then the identity rotation
      directed.push_back(make_req('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
      directed.push_back(make_req(32'sh0001_8000, 32'shFFFD_C000, 32'sh0064_0000,
                                  '0, '0, '0, FIX_ONE, FIX_ONE, FIX_ONE, FIX_ONE));
      // quarter turns about z and x, with doubling, halving and negative scale
      directed.push_back(make_req(-32'sd1, -32'sd1, -32'sd1,
                                  '0, '0, 32'sh0000_B505, 32'sh0000_B505,
                                  32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000));
      directed.push_back(make_req('0, '0, '0,
                                  32'sh0000_B505, '0, '0, 32'sh0000_B505,
                                  -FIX_ONE, 32'sh0000_8000, 32'shFFFD_0000));
      // quaternion far from unit length, translation at both ends
      directed.push_back(make_req(FIX_MAX, FIX_MIN, '0,
                                  32'sh0002_0000, 32'sh0003_0000, 32'shFFFE_8000,
                                  32'sh0000_8000, FIX_ONE, FIX_ONE, FIX_ONE));
      // single-lsb components: negative products floor to -1
      directed.push_back(make_req('0, '0, '0, -32'sd1, 32'sd1, -32'sd1, 32'sd1,
                                  FIX_ONE, FIX_ONE, FIX_ONE));
      // every field at one extreme or the other, except one translation at zero
      directed.push_back(make_req(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX,
                                  FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
      directed.push_back(make_req(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN,
                                  FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN));
      directed.push_back(make_req(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MIN, FIX_MIN, FIX_MIN,
                                  FIX_MIN, FIX_MAX, FIX_MAX, FIX_MAX));
      directed.push_back(make_req(FIX_MIN, '0, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX,
                                  FIX_MAX, FIX_MIN, FIX_MIN, FIX_MIN));
      // diagonal term just above the lower bound, then with one lsb more in x
      directed.push_back(make_req('0, '0, '0, 32'sh0080_0000, '0, '0, '0,
                                  FIX_ONE, FIX_ONE, FIX_ONE));
      directed.push_back(make_req('0, '0, '0, 32'sh0080_0001, '0, '0, '0,
                                  FIX_ONE, FIX_ONE, FIX_ONE));
      // off-diagonal term reaching exactly 2^31, just past the upper bound
      directed.push_back(make_req('0, '0, '0, 32'sh0080_0000, 32'sh0080_0000, '0, '0,
                                  FIX_ONE, FIX_ONE, FIX_ONE));
      // scaled element saturates while the rotation element itself does not
      directed.push_back(make_req('0, '0, '0, FIX_ONE, FIX_ONE, '0, '0,
                                  FIX_MAX, FIX_MAX, FIX_MIN));
      // alternating bit patterns over every field
      directed.push_back(make_req(32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                                  32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                                  32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                                  32'shAAAA_AAAA));
      directed.push_back(make_req(32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
                                  32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
                                  32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
                                  32'sh5555_5555));
      // mixed signs with two tiny scales and one large, so flooring of negative products shows
      directed.push_back(make_req(32'sh1234_5678, 32'sh8765_4321, -32'sd2,
                                  32'shFFFF_8000, 32'sh0001_4000, 32'shFFFF_FFFE,
                                  32'sh0000_C000, 32'sd3, -32'sd3, 32'sh7FFF_0000));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[k]) begin
         gap = pick_gap();
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         push_request(directed[k]);
      end

      // two windows run back to back with the response side always ready
      for (int n = 0; n < RANDOM_REQS; n++) begin
         calm = (n >= 100 && n < 150) || (n >= 240 && n < 270);
         steady <= calm;
         gap = calm ? 0 : pick_gap();
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         push_request(rand_req());
      end
      req_valid <= 1'b0;
      steady    <= 1'b0;

      // drain, then idle on to catch any stray row
      while (book.pending() != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);

      if (book.faults == 0) begin
         $display("trs_transform_compose verification clean");
      end else begin
         $display("trs_transform_compose verification failed");
      end
      $finish;
   end

   // response side: checks each taken row and stalls the block at random
   initial begin : rsp_side
      mat_row_type seen;
      int unsigned left;
      logic        ready_now;
      left      = 0;
      ready_now = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            seen.row_index = rsp_row_index;
            seen.col0      = rsp_col0;
            seen.col1      = rsp_col1;
            seen.col2      = rsp_col2;
            seen.col3      = rsp_col3;
            seen.last_row  = rsp_last_row;
            book.check_row(seen);
         end
         // alternate ready bursts with stalls drawn like the request gaps
         if (steady) begin
            ready_now = 1'b1;
            left      = 0;
         end else begin
            if (left == 0) begin
               left      = ready_now ? pick_gap() : 0;
               ready_now = (left == 0);
               if (ready_now) begin
                  left = $urandom_range(1, 24);
               end
            end
            left--;
         end
         rsp_ready <= ready_now;
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("trs_transform_compose verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/trs_pkg.sv
rtl/trs_prod.sv
rtl/trs_rot.sv
rtl/trs_scale.sv
rtl/trs_rows.sv
rtl/trs_transform_compose.sv
tb/trs_row_ledger_pkg.sv
tb/trs_transform_compose_tb.sv
